/* design/clrb_pkg.sv */
// Shared types and constants for the console line ring buffer.
package clrb_pkg;

  localparam int CODE_W  = 21;
  localparam int GLYPH_W = 8;
  localparam int INDEX_W = 12;
  localparam int ROWS_W  = 9;
  localparam int SCROLL_W = 16;
  localparam int PX_W    = 13;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CODE_W-1:0]      NEWLINE_CODE = 21'd10;
  localparam logic [SCROLL_W-1:0]    SCROLL_MAX   = 16'hFFFF;
  localparam logic [PX_W-1:0]        SCREEN_WIDTH_RESET = 13'd1024;
  localparam logic [ROWS_W-1:0]      SCREEN_ROWS_RESET  = 9'd48;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS  = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0]  char_code;
    logic [GLYPH_W-1:0] glyph_width;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  write_index;
    logic [INDEX_W-1:0]  read_index;
    logic [ROWS_W-1:0]   rows_used;
    logic [SCROLL_W-1:0] scrolls;
    logic [PX_W-1:0]     row_fill_px;
    logic                overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NL_WRITE,
    ST_SCAN_ISSUE,
    ST_SCAN,
    ST_CHAR_WRITE,
    ST_REPORT
  } state_t;

endpackage

/* design/clrb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module clrb_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/console_line_ring_buffer.sv */
// Top level of the console line ring buffer: control, counters and the character ring.
// A refused request goes straight to the done strobe; a plain character is written first, and
// a newline is written first too, followed by the character when a character forces a newline;
// when a newline scrolls, the walk over the oldest row, its newline included, comes in between.
// busy drops the cycle after the strobe.
// Synchronous reset clears the pointers and counters and restores the configuration
// defaults; ring contents are left as they are. The receiver cannot stall.
module console_line_ring_buffer
  import clrb_pkg::*;
#(
  parameter int RING_DEPTH = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  // Advance a ring position by one, wrapping at the ring depth (which need not be a
  // power of two).
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  state_t state, state_next;

  // Architectural state.
  logic [PW-1:0]       write_ptr;
  logic [PW-1:0]       read_ptr;
  logic [ROWS_W-1:0]   row_total;
  logic [SCROLL_W-1:0] scroll_total;
  logic [PX_W-1:0]     fill_px;
  logic [PX_W-1:0]     screen_width_px;
  logic [ROWS_W-1:0]   screen_rows;

  // Request being worked on.
  logic [CODE_W-1:0]   code;
  logic [GLYPH_W-1:0]  glyph;
  logic                pend_char;  // a character still has to be stored after a newline
  logic                refused;
  logic [PW-1:0]       scan_cnt;   // steps taken by the scroll walk

  // Ring port.
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [CODE_W-1:0]   ram_wdata;
  logic [PW-1:0]       ram_raddr;
  logic [CODE_W-1:0]   ram_rdata;

  logic                accept;
  logic                refuse;
  logic                wrap;
  logic [PX_W:0]       fill_sum;
  logic [ROWS_W:0]     rows_inc;
  logic                scroll_need;
  logic                scan_stop;
  logic [PW-1:0]       write_ptr_inc;
  logic [PW-1:0]       read_ptr_inc;

  clrb_ram #(
    .WIDTH(CODE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign write_ptr_inc = ptr_inc(write_ptr);
  assign read_ptr_inc  = ptr_inc(read_ptr);
  assign accept        = start && !busy;

  // The ring counts as nearly full when the write position would come within two
  // entries of the first visible character.
  assign refuse = (write_ptr_inc == read_ptr) || (ptr_inc(write_ptr_inc) == read_ptr);

  // A glyph that does not fit in the remaining row width forces a newline first,
  // even into an empty row.
  assign fill_sum = {1'b0, fill_px} + (PX_W + 1)'(item.glyph_width);
  assign wrap     = fill_sum > {1'b0, screen_width_px};

  // Closing a row scrolls when the new row count exceeds the visible rows.
  assign rows_inc    = {1'b0, row_total} + (ROWS_W + 1)'(1);
  assign scroll_need = rows_inc > {1'b0, screen_rows};

  // The walk ends on the oldest row's newline, or after a full lap of the ring.
  assign scan_stop = (ram_rdata == NEWLINE_CODE) || (scan_cnt == PTR_LAST);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (refuse) begin
            state_next = ST_REPORT;
          end else if (item.char_code == NEWLINE_CODE || wrap) begin
            state_next = ST_NL_WRITE;
          end else begin
            state_next = ST_CHAR_WRITE;
          end
        end
      end
      ST_NL_WRITE: begin
        if (scroll_need) begin
          state_next = ST_SCAN_ISSUE;
        end else if (pend_char) begin
          state_next = ST_CHAR_WRITE;
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_SCAN_ISSUE: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_stop) begin
          state_next = pend_char ? ST_CHAR_WRITE : ST_REPORT;
        end
      end
      ST_CHAR_WRITE: state_next = ST_REPORT;
      ST_REPORT:     state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Outputs and ring control.
  always_comb begin
    busy      = (state != ST_IDLE);
    done      = (state == ST_REPORT);
    cfg_ready = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = write_ptr;
    ram_wdata = code;
    // During the walk the read for the next entry goes out while the current one
    // is checked, so the walk advances one entry per cycle.
    ram_raddr = read_ptr;
    case (state)
      ST_NL_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = NEWLINE_CODE;
      end
      ST_SCAN:       ram_raddr = read_ptr_inc;
      ST_CHAR_WRITE: ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  assign result.write_index = INDEX_W'(write_ptr);
  assign result.read_index  = INDEX_W'(read_ptr);
  assign result.rows_used   = row_total;
  assign result.scrolls     = scroll_total;
  assign result.row_fill_px = fill_px;
  assign result.overflow    = refused;

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_ptr       <= '0;
      read_ptr        <= '0;
      row_total       <= '0;
      scroll_total    <= '0;
      fill_px         <= '0;
      screen_width_px <= SCREEN_WIDTH_RESET;
      screen_rows     <= SCREEN_ROWS_RESET;
      pend_char       <= 1'b0;
      refused         <= 1'b0;
      scan_cnt        <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH: screen_width_px <= cfg_data;
          REG_SCREEN_ROWS:  screen_rows     <= cfg_data[ROWS_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            refused   <= refuse;
            pend_char <= (item.char_code != NEWLINE_CODE);
          end
        end
        ST_NL_WRITE: begin
          write_ptr <= write_ptr_inc;
          fill_px   <= '0;
          // With a scroll the count rises and falls by one, so it stays put.
          if (!scroll_need) begin
            row_total <= rows_inc[ROWS_W-1:0];
          end
        end
        ST_SCAN_ISSUE: scan_cnt <= '0;
        ST_SCAN: begin
          read_ptr <= read_ptr_inc;
          scan_cnt <= scan_cnt + PW'(1);
          if (scan_stop && scroll_total != SCROLL_MAX) begin
            scroll_total <= scroll_total + SCROLL_W'(1);
          end
        end
        ST_CHAR_WRITE: begin
          write_ptr <= write_ptr_inc;
          fill_px   <= fill_px + PX_W'(glyph);
        end
        default: begin
        end
      endcase
    end
  end

  // Request payload, captured on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      code  <= item.char_code;
      glyph <= item.glyph_width;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the console line ring buffer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clrb_pkg::*;

  localparam int DEPTH = 4096;
  // A scroll walks at most one ring's worth of entries, so a healthy block never
  // goes this long without moving a request, a result or a register write.
  localparam int STALL_LIMIT = 20000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 90;

  // One pending operation for the driver: either a character request or a
  // register write. The gap is the idle time inserted before it is presented.
  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_sel;
    logic [CFG_DATA_W-1:0]  reg_value;
    item_t                  req;
    int                     gap;
  } console_op_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  item_t                  item = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  console_op_t console_ops[$];
  result_t     pending_results[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  int          gap_left = 0;
  bit          gap_loaded = 1'b0;
  bit          no_idle = 1'b0;

  // Shadow copy of the console state, advanced once per accepted request.
  logic [CODE_W-1:0]   shadow_ring [DEPTH];
  logic [INDEX_W-1:0]  head_ptr = '0;
  logic [INDEX_W-1:0]  view_ptr = '0;
  logic [ROWS_W-1:0]   row_count = '0;
  logic [SCROLL_W-1:0] rows_scrolled = '0;
  logic [PX_W-1:0]     fill_now = '0;
  logic [PX_W-1:0]     width_setting = SCREEN_WIDTH_RESET;
  logic [ROWS_W-1:0]   rows_setting = SCREEN_ROWS_RESET;

  console_line_ring_buffer #(.RING_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Store a newline and close the row. When the screen then holds too many
  // rows, the view pointer walks past the oldest row, newline included. The
  // walk always meets the newline just written, so it only reads stored text.
  function void end_row();
    int rows;
    int steps;
    bit walk_done;
    shadow_ring[head_ptr] = NEWLINE_CODE;
    head_ptr = INDEX_W'(head_ptr + 1);
    fill_now = '0;
    rows = int'(row_count) + 1;
    if (rows > int'(rows_setting)) begin
      walk_done = 1'b0;
      for (steps = 0; steps < DEPTH && !walk_done; steps++) begin
        if (shadow_ring[view_ptr] == NEWLINE_CODE) walk_done = 1'b1;
        view_ptr = INDEX_W'(view_ptr + 1);
      end
      rows = rows - 1;
      if (rows_scrolled != SCROLL_MAX) rows_scrolled = rows_scrolled + 1'b1;
    end
    row_count = ROWS_W'(rows);
  endfunction

  // Advance the shadow state by one character request and return the result
  // the block should report for it.
  function result_t apply_char(item_t req);
    bit refuse;
    result_t outcome;
    // The ring counts as full two entries ahead of the view pointer; a refused
    // request leaves everything untouched and only raises the overflow flag.
    refuse = (INDEX_W'(head_ptr + 1) == view_ptr) || (INDEX_W'(head_ptr + 2) == view_ptr);
    if (!refuse) begin
      if (req.char_code == NEWLINE_CODE) begin
        end_row();
      end else begin
        // A glyph that does not fit wraps first, even out of an empty row.
        if (int'(fill_now) + int'(req.glyph_width) > int'(width_setting)) end_row();
        shadow_ring[head_ptr] = req.char_code;
        head_ptr = INDEX_W'(head_ptr + 1);
        fill_now = PX_W'(fill_now + req.glyph_width);
      end
    end
    outcome.write_index = head_ptr;
    outcome.read_index  = view_ptr;
    outcome.rows_used   = row_count;
    outcome.scrolls     = rows_scrolled;
    outcome.row_fill_px = fill_now;
    outcome.overflow    = refuse;
    return outcome;
  endfunction

  task automatic push_char(input logic [CODE_W-1:0] code, input int glyph);
    console_op_t op;
    op.is_cfg    = 1'b0;
    op.reg_sel   = REG_SCREEN_WIDTH;
    op.reg_value = '0;
    op.req.char_code   = code;
    op.req.glyph_width = GLYPH_W'(glyph);
    op.gap = no_idle ? 0 : $urandom_range(0, 18);
    console_ops.push_back(op);
  endtask

  task automatic push_setting(input logic [CFG_INDEX_W-1:0] sel, input int value);
    console_op_t op;
    op.is_cfg    = 1'b1;
    op.reg_sel   = sel;
    op.reg_value = CFG_DATA_W'(value);
    op.req       = '0;
    op.gap       = no_idle ? 0 : $urandom_range(0, 18);
    console_ops.push_back(op);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver. Handshakes that complete at this edge are retired first, then the
  // next operation is picked up, so start and cfg_valid each get exactly one
  // nonblocking update per edge and a back-to-back request keeps start high.
  // Register writes wait until every expected result is in and the block is idle.
  always @(posedge clk) begin : driver
    logic start_nxt;
    logic cfg_nxt;
    if (rst) begin
      start      <= 1'b0;
      cfg_valid  <= 1'b0;
      gap_loaded = 1'b0;
      gap_left   = 0;
    end else begin
      start_nxt = start;
      cfg_nxt   = cfg_valid;
      if (start && !busy) begin
        pending_results.push_back(apply_char(item));
        start_nxt = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_WIDTH) width_setting = cfg_data[PX_W-1:0];
        else rows_setting = cfg_data[ROWS_W-1:0];
        cfg_nxt = 1'b0;
      end
      if (!start_nxt && !cfg_nxt && console_ops.size() != 0) begin
        if (!gap_loaded) begin
          gap_left   = console_ops[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!console_ops[0].is_cfg) begin
          item      <= console_ops[0].req;
          start_nxt = 1'b1;
          void'(console_ops.pop_front());
          gap_loaded = 1'b0;
        end else if (pending_results.size() == 0 && !busy) begin
          cfg_index <= console_ops[0].reg_sel;
          cfg_data  <= console_ops[0].reg_value;
          cfg_nxt   = 1'b1;
          void'(console_ops.pop_front());
          gap_loaded = 1'b0;
        end
      end
      start     <= start_nxt;
      cfg_valid <= cfg_nxt;
    end
  end

  // Monitor. The receiver cannot push back, so every strobed result is taken
  // at the edge that ends its cycle and checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("write_index", want.write_index, result.write_index);
        compare_field("read_index", want.read_index, result.read_index);
        compare_field("rows_used", want.rows_used, result.rows_used);
        compare_field("scrolls", want.scrolls, result.scrolls);
        compare_field("row_fill_px", want.row_fill_px, result.row_fill_px);
        compare_field("overflow", want.overflow, result.overflow);
      end
    end
  end

  // Watchdog: a run that stops moving requests, results and writes is a failure.
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int width_px;
    int rows;
    logic [CODE_W-1:0] code;
    int glyph;

    // Directed part under the reset configuration (1024 px, 48 rows): code
    // extremes, newline with its width field ignored, and a row filled to
    // exactly the screen width before one more pixel forces a wrap.
    push_char(21'd0, 0);
    push_char(21'd1114111, 255);
    push_char(21'd11, 255);
    push_char(21'd9, 255);
    push_char(NEWLINE_CODE, 255);
    push_char(NEWLINE_CODE, 0);
    push_char(21'h0F0000, 255);
    push_char(21'h041, 255);
    push_char(21'h0FFFF, 255);
    push_char(21'h042, 255);
    push_char(21'h043, 4);
    push_char(21'h044, 1);

    // One-pixel rows and a one-row screen: every glyph wider than the row wraps
    // even out of an empty row, and each new row scrolls the oldest one away.
    push_setting(REG_SCREEN_WIDTH, 1);
    push_setting(REG_SCREEN_ROWS, 1);
    push_char(21'h045, 255);
    push_char(21'h046, 1);
    push_char(21'h047, 0);
    push_char(NEWLINE_CODE, 7);
    push_char(NEWLINE_CODE, 0);

    // A screen with no rows scrolls on every newline.
    push_setting(REG_SCREEN_ROWS, 0);
    push_char(NEWLINE_CODE, 0);
    push_char(21'h048, 0);
    push_char(NEWLINE_CODE, 3);
    push_char(21'h049, 255);

    // Random part: several screen geometries, the extremes among them, with
    // mostly printable text, a steady share of newlines and mixed glyph widths.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin width_px = 4096; rows = 256; end
        1: begin width_px = 1; rows = 1; end
        2: begin width_px = $urandom_range(1, 4096); rows = $urandom_range(1, 4); end
        3: begin width_px = $urandom_range(1, 300); rows = $urandom_range(1, 16); end
        4: begin width_px = SCREEN_WIDTH_RESET; rows = SCREEN_ROWS_RESET; end
        5: begin width_px = $urandom_range(1, 4096); rows = $urandom_range(1, 256); end
        default: begin width_px = $urandom_range(40, 400); rows = 2; end
      endcase
      push_setting(REG_SCREEN_WIDTH, width_px);
      push_setting(REG_SCREEN_ROWS, rows);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Switch now and then between idling and back-to-back requests.
        if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
        case ($urandom_range(0, 5))
          0: code = NEWLINE_CODE;
          1: code = CODE_W'($urandom_range(0, 1114111));
          default: code = CODE_W'($urandom_range(32, 126));
        endcase
        if ($urandom_range(0, 1) == 0) glyph = $urandom_range(0, 255);
        else glyph = $urandom_range(0, 16);
        push_char(code, glyph);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait on the falling edge so that the driver's updates have settled.
    do @(negedge clk);
    while (console_ops.size() != 0 || start || cfg_valid || pending_results.size() != 0);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
design/clrb_pkg.sv
design/clrb_ram.sv
design/console_line_ring_buffer.sv
tb/sv/tb.sv
